// File: design/sha256_message_hasher_core_assert.svh
// Assertion macros for the SHA-256 hasher.
`ifndef SHA256_MESSAGE_HASHER_CORE_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SHA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SHA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/sha_pkg.sv
`default_nettype none
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Commands from controller to datapath
    typedef struct packed {
        logic       wr_byte;     // write wr_data at fill position, advance
        logic [7:0] wr_data;
        logic       add_bits;    // message_bits += 8
        logic       latch_len;   // hold current bit count for padding
        logic       comp_start;  // load working vars, round 0
        logic       comp_round;  // run one round
        logic       comp_final;  // fold working vars into chaining words
        logic       out_shift;   // rotate chaining words by one for emit
        logic       restart;     // back to initial hash values
    } t_cmd;

    typedef struct packed {
        logic [5:0] fill;
        logic [7:0] len_byte;    // length byte for current fill position
    } t_sts;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
        32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
        32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
        32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
        32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
        32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] rotr(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] d;
        d = {v, v} >> n;
        return d[31:0];
    endfunction

endpackage
`default_nettype wire

// File: design/sha_datapath.sv
`default_nettype none
module sha_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sha_pkg::t_cmd i_cmd,
    output sha_pkg::t_sts      o_sts,
    output logic [31:0]        o_h0
);
    logic [31:0] r_h [8];
    logic [31:0] r_s [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_fill;
    logic [5:0]  r_round;
    logic [63:0] r_bits;
    logic [63:0] r_len;
    logic [31:0] w_cur, w_new, s0, s1, t1, t2, ch, maj, bs0, bs1, wval;
    logic [31:0] n_w_in;

    // Message schedule: window of 16 words, w_cur is word t.
    always_comb begin
        s0    = sha_pkg::rotr(r_w[1], 5'd7) ^ sha_pkg::rotr(r_w[1], 5'd18) ^ (r_w[1] >> 3);
        s1    = sha_pkg::rotr(r_w[14], 5'd17) ^ sha_pkg::rotr(r_w[14], 5'd19)
                ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        w_cur = r_w[0];
        wval  = w_cur;
        bs1   = sha_pkg::rotr(r_s[4], 5'd6) ^ sha_pkg::rotr(r_s[4], 5'd11)
                ^ sha_pkg::rotr(r_s[4], 5'd25);
        ch    = (r_s[4] & r_s[5]) ^ (~r_s[4] & r_s[6]);
        t1    = r_s[7] + bs1 + ch + sha_pkg::ROUND_K[r_round] + wval;
        bs0   = sha_pkg::rotr(r_s[0], 5'd2) ^ sha_pkg::rotr(r_s[0], 5'd13)
                ^ sha_pkg::rotr(r_s[0], 5'd22);
        maj   = (r_s[0] & r_s[1]) ^ (r_s[0] & r_s[2]) ^ (r_s[1] & r_s[2]);
        t2    = bs0 + maj;
        n_w_in = {r_w[15][23:0], i_cmd.wr_data};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_bits <= '0;
            r_round <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::H_INIT[i];
        end else begin
            if (i_cmd.wr_byte) begin
                // shift bytes into the schedule window, big-endian words
                if (r_fill[1:0] == 2'd0) begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= {24'd0, i_cmd.wr_data};
                end else begin
                    r_w[15] <= n_w_in;
                end
            end else if (i_cmd.comp_round) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= w_new;
            end

            if (i_cmd.restart) r_fill <= '0;
            else if (i_cmd.wr_byte) r_fill <= r_fill + 6'd1;

            if (i_cmd.restart) r_bits <= '0;
            else if (i_cmd.add_bits) r_bits <= r_bits + 64'd8;

            if (i_cmd.latch_len) r_len <= r_bits;

            if (i_cmd.comp_start) begin
                for (int i = 0; i < 8; i++) r_s[i] <= r_h[i];
                r_round <= '0;
            end else if (i_cmd.comp_round) begin
                r_s[7] <= r_s[6];
                r_s[6] <= r_s[5];
                r_s[5] <= r_s[4];
                r_s[4] <= r_s[3] + t1;
                r_s[3] <= r_s[2];
                r_s[2] <= r_s[1];
                r_s[1] <= r_s[0];
                r_s[0] <= t1 + t2;
                r_round <= r_round + 6'd1;
            end

            if (i_cmd.restart) begin
                for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::H_INIT[i];
            end else if (i_cmd.comp_final) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_s[i];
            end else if (i_cmd.out_shift) begin
                for (int i = 0; i < 7; i++) r_h[i] <= r_h[i+1];
                r_h[7] <= r_h[0];
            end
        end
    end

    logic [2:0] lsel;
    always_comb begin
        lsel = 3'd7 - r_fill[2:0];
        o_sts.fill = r_fill;
        o_sts.len_byte = r_len[{lsel, 3'b000} +: 8];
        o_h0 = r_h[0];
    end
endmodule
`default_nettype wire

// File: design/sha_ctrl.sv
`default_nettype none
module sha_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sha_pkg::t_in_item i_item,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire sha_pkg::t_sts     i_sts,
    output sha_pkg::t_cmd          o_cmd,
    output logic                   o_out_valid,
    output logic [2:0]             o_word_idx,
    input  wire logic              i_out_stall
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_ROUND = 6'b000100,
        S_FOLD  = 6'b001000,
        S_PAD   = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic [2:0] r_widx, n_widx;
    logic r_fin, n_fin;           // message being finished
    logic r_pad1, n_pad1;         // 0x80 already placed
    logic r_last_blk, n_last_blk; // current pad block carries the length field

    assign o_out_valid = (r_state == S_EMIT);
    assign o_word_idx  = r_widx;
    assign o_stall     = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_widx     = r_widx;
        n_fin      = r_fin;
        n_pad1     = r_pad1;
        n_last_blk = r_last_blk;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_item.byte_present) begin
                        o_cmd.wr_byte  = 1'b1;
                        o_cmd.wr_data  = i_item.data_byte;
                        o_cmd.add_bits = 1'b1;
                    end
                    n_fin      = i_item.end_of_message;
                    n_pad1     = 1'b0;
                    n_last_blk = 1'b0;
                    if (i_item.byte_present && i_sts.fill == 6'd63) begin
                        n_state = S_START;
                    end else if (i_item.end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_START: begin
                o_cmd.comp_start = 1'b1;
                n_cnt   = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.comp_round = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) n_state = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.comp_final = 1'b1;
                n_widx = '0;
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (r_last_blk) begin
                    n_state = S_EMIT;
                end else begin
                    // a fresh block always has room for the length field
                    n_state    = S_PAD;
                    n_last_blk = 1'b1;
                end
            end
            S_PAD: begin
                o_cmd.wr_byte = 1'b1;
                if (!r_pad1) begin
                    o_cmd.latch_len = 1'b1;
                    o_cmd.wr_data   = sha_pkg::PAD_BYTE;
                    n_pad1     = 1'b1;
                    n_last_blk = (i_sts.fill <= 6'd55);
                end else if (r_last_blk && i_sts.fill >= 6'd56) begin
                    o_cmd.wr_data = i_sts.len_byte;
                end else begin
                    o_cmd.wr_data = 8'd0;
                end
                if (i_sts.fill == 6'd63) n_state = S_START;
            end
            S_EMIT: begin
                if (!i_out_stall) begin
                    n_widx = r_widx + 3'd1;
                    if (r_widx == 3'd7) begin
                        o_cmd.restart = 1'b1;
                        n_fin   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.out_shift = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_widx     <= '0;
            r_fin      <= 1'b0;
            r_pad1     <= 1'b0;
            r_last_blk <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_widx     <= n_widx;
            r_fin      <= n_fin;
            r_pad1     <= n_pad1;
            r_last_blk <= n_last_blk;
        end
    end
endmodule
`default_nettype wire

// File: design/sha256_message_hasher_core.sv
`default_nettype none
// Channel | direction | handshake         | payload
// in      | input     | i_valid / o_stall | sha_pkg::t_in_item
// out     | output    | o_valid / i_stall | sha_pkg::t_out_item
//
// Sequence: a byte that does not fill a block is absorbed directly; a byte that
// fills one starts a compression (start, 64 rounds of the single round unit, fold).
// End of message writes pad bytes and runs one or two compressions, then
// 8 digest transfers at one per unstalled cycle.
// Reset: synchronous, active low; chaining words go to initial values.
// Stalls: output stall holds the digest word; input is stalled while busy.
`include "sha256_message_hasher_core_assert.svh"
module sha256_message_hasher_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire sha_pkg::t_in_item  i_data,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output sha_pkg::t_out_item      o_data
);
    sha_pkg::t_cmd cmd;
    sha_pkg::t_sts sts;
    logic [31:0]   h0;
    logic [2:0]    widx;

    sha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_out_valid (o_valid),
        .o_word_idx  (widx),
        .i_out_stall (i_stall)
    );

    sha_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_h0    (h0)
    );

    // Present the current head chaining word.
    always_comb begin
        o_data.digest_word = h0;
        o_data.word_index  = widx;
        o_data.last_word   = (widx == 3'd7);
    end

    `SHA_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, o_valid, o_stall)
    `SHA_ASSERT_NXT(a_hold_word, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `SHA_ASSERT_NXT(a_last_idle, i_clk, i_rst_n, o_valid && !i_stall && o_data.last_word, !o_valid)
endmodule
`default_nettype wire

// File: tb/tb_sha256_message_hasher_core.sv
`default_nettype none
module tb_sha256_message_hasher_core;

    // Bit-exact SHA-256 digest predictor plus a queue of expected digest words.
    class digest_scoreboard;
        logic [31:0] hash_words [8];
        logic [7:0]  blk [64];
        int unsigned fill;
        logic [63:0] bit_len;
        sha_pkg::t_out_item pending_words [$];
        int unsigned n_errors;

        function new();
            n_errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) hash_words[i] = sha_pkg::H_INIT[i];
            fill = 0;
            bit_len = '0;
        endfunction

        function logic [31:0] rr(logic [31:0] v, int n);
            return (v >> n) | (v << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] s [8];
            logic [31:0] t1, t2, x, y;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 16; i < 64; i++) begin
                x = w[i-15];
                y = w[i-2];
                w[i] = (rr(y, 17) ^ rr(y, 19) ^ (y >> 10)) + w[i-7]
                     + (rr(x, 7) ^ rr(x, 18) ^ (x >> 3)) + w[i-16];
            end
            for (int i = 0; i < 8; i++) s[i] = hash_words[i];
            for (int i = 0; i < 64; i++) begin
                t1 = s[7] + (rr(s[4], 6) ^ rr(s[4], 11) ^ rr(s[4], 25))
                   + ((s[4] & s[5]) ^ (~s[4] & s[6])) + sha_pkg::ROUND_K[i] + w[i];
                t2 = (rr(s[0], 2) ^ rr(s[0], 13) ^ rr(s[0], 22))
                   + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
                for (int j = 7; j > 0; j--) s[j] = s[j-1];
                s[4] = s[4] + t1;
                s[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) hash_words[i] += s[i];
        endfunction

        function void absorb(logic [7:0] b);
            blk[fill] = b;
            fill = (fill + 1) % 64;
            if (fill == 0) compress();
        endfunction

        // Note one accepted input transfer.
        function void note_input(sha_pkg::t_in_item it);
            logic [63:0] len;
            sha_pkg::t_out_item o;
            if (it.byte_present) begin
                absorb(it.data_byte);
                bit_len += 64'd8;
            end
            if (!it.end_of_message) return;
            len = bit_len;
            absorb(sha_pkg::PAD_BYTE);
            while (fill != 56) absorb(8'h00);
            for (int i = 0; i < 8; i++) absorb(len[63-8*i -: 8]);
            for (int i = 0; i < 8; i++) begin
                o.digest_word = hash_words[i];
                o.word_index = 3'(i);
                o.last_word = (i == 7);
                pending_words = {pending_words, o};
            end
            restart();
        endfunction

        // Check one output transfer against the oldest expected word.
        function void check_output(sha_pkg::t_out_item got);
            sha_pkg::t_out_item exp_w;
            if (pending_words.size() == 0) begin
                $error("unexpected digest word %h", got.digest_word);
                n_errors++;
                return;
            end
            exp_w = pending_words.pop_front();
            if (got.digest_word !== exp_w.digest_word) begin
                $error("digest_word exp %h got %h", exp_w.digest_word, got.digest_word);
                n_errors++;
            end
            if (got.word_index !== exp_w.word_index) begin
                $error("word_index exp %0d got %0d", exp_w.word_index, got.word_index);
                n_errors++;
            end
            if (got.last_word !== exp_w.last_word) begin
                $error("last_word exp %0d got %0d", exp_w.last_word, got.last_word);
                n_errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    sha_pkg::t_in_item  i_data = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    sha_pkg::t_out_item o_data;

    digest_scoreboard sb = new();
    bit stim_done = 1'b0;
    bit long_holdoff = 1'b0;
    int unsigned burst_left = 0;

    sha256_message_hasher_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    always #5 i_clk = ~i_clk;

    // Sample both channels at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_input(i_data);
            if (o_valid && !i_stall) sb.check_output(o_data);
        end
    end

    // Receiver stall pattern: random stalls, calm stretches, and one long hold-off.
    initial begin
        int unsigned mode;
        forever begin
            @(negedge i_clk);
            if (long_holdoff) begin
                i_stall <= 1'b1;
            end else begin
                mode = 32'(($time / 4000) % 3);
                if (mode == 0) i_stall <= 1'b0;
                else if (mode == 1) i_stall <= ($urandom_range(0, 3) == 0);
                else i_stall <= ($urandom_range(0, 1) == 0);
            end
        end
    end

    // Offer one transfer and hold it until accepted; gaps come between bursts.
    task automatic send_item(sha_pkg::t_in_item it);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic send_byte(logic [7:0] b, bit eom);
        sha_pkg::t_in_item it;
        it.data_byte = b;
        it.byte_present = 1'b1;
        it.end_of_message = eom;
        send_item(it);
    endtask

    task automatic send_flags(logic [7:0] b, bit bp, bit eom);
        sha_pkg::t_in_item it;
        it.data_byte = b;
        it.byte_present = bp;
        it.end_of_message = eom;
        send_item(it);
    endtask

    // Hold the sender until every expected digest word has come out.
    task automatic drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending_words.size() != 0);
    endtask

    // Send a message of given length; end marker with or without a final byte.
    task automatic send_message(int unsigned len);
        bit with_byte;
        with_byte = (len > 0) && $urandom_range(0, 1);
        for (int i = 0; i < len - with_byte; i++) begin
            if ($urandom_range(0, 9) == 0) send_flags(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        if (with_byte) send_byte(8'($urandom_range(0, 255)), 1'b1);
        else send_flags(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial begin
        int unsigned len;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty message, ignored items, byte extremes, end with byte.
        send_flags(8'hFF, 1'b0, 1'b0);
        send_flags(8'h00, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_flags(8'h00, 1'b0, 1'b1);
        drain();

        // Long receiver hold-off while the sender keeps offering a message.
        fork
            begin
                long_holdoff = 1'b1;
                repeat (400) @(negedge i_clk);
                long_holdoff = 1'b0;
            end
            begin
                send_message(3);
                send_message(5);
            end
        join
        drain();

        // Padding boundaries: 55, 56, 63, 64 bytes.
        send_message(55);
        send_message(56);
        drain();
        send_message(63);
        send_message(64);

        // Random short messages.
        for (int m = 0; m < 13; m++) begin
            len = $urandom_range(0, 12);
            send_message(len);
            if ($urandom_range(0, 5) == 0) drain();
        end

        drain();
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        repeat (200) @(posedge i_clk);
        if (sb.n_errors == 0 && sb.pending_words.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
+incdir+design
design/sha_pkg.sv
design/sha_datapath.sv
design/sha_ctrl.sv
design/sha256_message_hasher_core.sv
tb/tb_sha256_message_hasher_core.sv
